### src/pvb_pkg.sv
// ----------------------------------------------------------------------------
// pvb_pkg
// Shared types and constants of the point voxel binning block.
// ----------------------------------------------------------------------------
package pvb_pkg;

  localparam int unsigned VoxelSlotsDef = 1024;
  localparam int unsigned ClassCountDef = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned DivSteps = 33;

  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VOXEL_SZ = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CLS_MASK = 3'd4;

  localparam logic [30:0] VoxelSizeRst = 31'd1024;

  typedef struct packed {
    logic [23:0]        point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         class_code;
  } in_t;

  typedef struct packed {
    logic [23:0]        echo_index;
    logic               accepted;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic [SlotW-1:0]   slot;
    logic               first_in_cell;
    logic [23:0]        cell_count;
    logic [23:0]        prior_point;
    logic               has_prior;
    logic               table_full;
  } out_t;

  typedef struct packed {
    logic [47:0] key;
    logic [23:0] count;
    logic [23:0] head;
  } entry_t;

endpackage

### src/point_voxel_binning.sv
// ----------------------------------------------------------------------------
// point_voxel_binning
// Voxel grid binning: divides each axis offset from the origin by the voxel
// size, looks the cell key up in the slot table and updates the slot count
// and last-point head, or opens a new slot on a miss while the table has room.
// Flow: a rejected class goes straight to output; else bit-serial dividers,
//   then a scan of the used slots, which dominates; one point at a time.
// Reset: asynchronous, clears slot fill count and control; config to defaults.
// The slot memory needs no clearing pass: entries at or above the fill count
//   are never read.
// ----------------------------------------------------------------------------
module point_voxel_binning #(
  parameter int unsigned VOXEL_SLOTS = pvb_pkg::VoxelSlotsDef,
  parameter int unsigned CLASS_COUNT = pvb_pkg::ClassCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pvb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pvb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pvb_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pvb_pkg::out_t                out_data_o
);

  localparam int unsigned AW = $clog2(VOXEL_SLOTS);
  localparam int unsigned UW = $clog2(VOXEL_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // configuration
  logic signed [31:0] org_q [3];
  logic [30:0]        vsize_q;
  logic [31:0]        cmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      vsize_q  <= pvb_pkg::VoxelSizeRst;
      cmask_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pvb_pkg::REG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        pvb_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        pvb_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        pvb_pkg::REG_VOXEL_SZ: vsize_q  <= cfg_wdata_i[30:0];
        pvb_pkg::REG_CLS_MASK: cmask_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [30:0] size_eff;
  assign size_eff = (vsize_q == '0) ? 31'd1 : vsize_q;

  // control and payload registers
  logic [1:0]         state_q, state_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [UW-1:0]      used_q, used_d;
  logic [UW-1:0]      scan_q, scan_d;
  logic [AW-1:0]      cmp_addr_q, cmp_addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic               out_vld_q, out_vld_d;
  pvb_pkg::out_t      out_q, out_d;
  pvb_pkg::out_t      res_q, res_d;
  logic [23:0]        idx_q, idx_d;
  logic [32:0]        quo_q [3];
  logic [32:0]        quo_d [3];
  logic [30:0]        rem_q [3];
  logic [30:0]        rem_d [3];
  logic               neg_q [3];
  logic               neg_d [3];
  logic [15:0]        cell_q [3];
  logic [15:0]        cell_d [3];

  // slot memory
  pvb_pkg::entry_t    mem [VOXEL_SLOTS];
  pvb_pkg::entry_t    rd_data_q;
  pvb_pkg::entry_t    wr_data;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // input decode
  logic       cls_ok;
  logic [47:0] key;
  logic       hit;
  logic [23:0] cnt_inc;
  logic [32:0] diff [3];
  logic [31:0] trial [3];
  logic        ge [3];
  logic [15:0] sat [3];

  assign cls_ok = (in_data_i.class_code < 8'(CLASS_COUNT)) &&
                  cmask_q[in_data_i.class_code[4:0]];
  assign key     = {cell_q[0], cell_q[1], cell_q[2]};
  assign hit     = rd_vld_q && (rd_data_q.key == key);
  assign cnt_inc = (rd_data_q.count < 24'hFFFFFF) ? rd_data_q.count + 24'd1
                                                  : rd_data_q.count;

  always_comb begin
    diff[0] = {in_data_i.pos_x[31], in_data_i.pos_x} - {org_q[0][31], org_q[0]};
    diff[1] = {in_data_i.pos_y[31], in_data_i.pos_y} - {org_q[1][31], org_q[1]};
    diff[2] = {in_data_i.pos_z[31], in_data_i.pos_z} - {org_q[2][31], org_q[2]};
    for (int a = 0; a < 3; a++) begin
      // one restoring division step per cycle
      trial[a] = {rem_q[a], quo_q[a][32]};
      ge[a]    = trial[a] >= {1'b0, size_eff};
      rem_d[a] = ge[a] ? 31'(trial[a] - {1'b0, size_eff}) : trial[a][30:0];
      quo_d[a] = {quo_q[a][31:0], ge[a]};
      neg_d[a] = neg_q[a];
      if (neg_q[a]) begin
        sat[a] = (quo_d[a] > 33'd32768) ? 16'h8000 : 16'(-quo_d[a][15:0]);
      end else begin
        sat[a] = (quo_d[a] > 33'd32767) ? 16'h7FFF : quo_d[a][15:0];
      end
      cell_d[a] = cell_q[a];
    end

    state_d    = state_q;
    cnt_d      = cnt_q;
    used_d     = used_q;
    scan_d     = scan_q;
    cmp_addr_d = cmp_addr_q;
    rd_vld_d   = 1'b0;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    res_d      = res_q;
    idx_d      = idx_q;
    rd_en      = 1'b0;
    rd_addr    = scan_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cmp_addr_q;
    wr_data    = '0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = in_data_i.point_index;
          if (cls_ok) begin
            for (int a = 0; a < 3; a++) begin
              neg_d[a] = diff[a][32];
              quo_d[a] = diff[a][32] ? -diff[a] : diff[a];
              rem_d[a] = '0;
            end
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            res_d            = '0;
            res_d.echo_index = in_data_i.point_index;
            state_d          = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(pvb_pkg::DivSteps - 1)) begin
          for (int a = 0; a < 3; a++) begin
            cell_d[a] = sat[a];
          end
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_d            = '0;
        res_d.echo_index = idx_q;
        res_d.cell_x     = cell_q[0];
        res_d.cell_y     = cell_q[1];
        res_d.cell_z     = cell_q[2];
        if (hit) begin
          wr_en               = 1'b1;
          wr_addr             = cmp_addr_q;
          wr_data.key         = key;
          wr_data.count       = cnt_inc;
          wr_data.head        = idx_q;
          res_d.accepted      = 1'b1;
          res_d.slot          = pvb_pkg::SlotW'(cmp_addr_q);
          res_d.cell_count    = cnt_inc;
          res_d.prior_point   = rd_data_q.head;
          res_d.has_prior     = 1'b1;
          state_d             = ST_OUT;
        end else if (!rd_vld_q && scan_q == used_q) begin
          if (used_q < UW'(VOXEL_SLOTS)) begin
            wr_en               = 1'b1;
            wr_addr             = used_q[AW-1:0];
            wr_data.key         = key;
            wr_data.count       = 24'd1;
            wr_data.head        = idx_q;
            used_d              = used_q + 1'b1;
            res_d.accepted      = 1'b1;
            res_d.slot          = pvb_pkg::SlotW'(used_q[AW-1:0]);
            res_d.first_in_cell = 1'b1;
            res_d.cell_count    = 24'd1;
          end else begin
            res_d.table_full = 1'b1;
          end
          state_d = ST_OUT;
        end else if (scan_q < used_q) begin
          // issue the next read; its data is compared next cycle
          rd_en      = 1'b1;
          rd_vld_d   = 1'b1;
          cmp_addr_d = scan_q[AW-1:0];
          scan_d     = scan_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      used_q    <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      scan_q    <= scan_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q <= cmp_addr_d;
    out_q      <= out_d;
    res_q      <= res_d;
    idx_q      <= idx_d;
    for (int a = 0; a < 3; a++) begin
      quo_q[a]  <= quo_d[a];
      rem_q[a]  <= rem_d[a];
      neg_q[a]  <= neg_d[a];
      cell_q[a] <= cell_d[a];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(VOXEL_SLOTS))
    else $error("slot fill count beyond table depth");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("table read pending outside scan");

  a_first_no_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.first_in_cell) |->
      (!out_q.has_prior && out_q.cell_count == 24'd1))
    else $error("new slot with prior point");

  a_full_not_binned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.table_full) |-> !out_q.accepted)
    else $error("point binned on full table");

  a_grow_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> $past(state_q == ST_SCAN))
    else $error("fill count moved outside scan");

endmodule
